// ===== src/dlq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the delta-list timer queue.
// Used by the channel interfaces and by the queue core; depends on nothing.
package dlq_pkg;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 2;
  localparam int TICK_W   = 32;
  localparam int KIND_W   = 2;

  // Operation carried by an input word.
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_SET     = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_SERVICE = 2'd3
  } action_t;

  // Kind of a result word.
  typedef enum logic [KIND_W-1:0] {
    K_FIRED   = 2'd0,
    K_QUERY   = 2'd1,
    K_SET_ACK = 2'd2
  } kind_t;

endpackage

// ===== src/dlq_in_if.sv =====
`timescale 1ns / 1ps
// Command channel of the delta-list timer queue: valid/ready plus the command word.
// Depends on dlq_pkg for the field widths.
interface dlq_in_if;
  logic                           valid;
  logic                           ready;
  logic [dlq_pkg::ACTION_W-1:0]   action;
  logic [dlq_pkg::ID_W-1:0]       timer_id;
  logic [dlq_pkg::TICK_W-1:0]     start_value;
  logic [dlq_pkg::TICK_W-1:0]     period;

  modport source (output valid, action, timer_id, start_value, period, input ready);
  modport sink   (input valid, action, timer_id, start_value, period, output ready);
endinterface

// ===== src/dlq_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the delta-list timer queue: valid/ready plus the result word.
// Depends on dlq_pkg for the field widths.
interface dlq_out_if;
  logic                         valid;
  logic                         ready;
  logic [dlq_pkg::KIND_W-1:0]   kind;
  logic [dlq_pkg::ID_W-1:0]     timer_id_res;
  logic [dlq_pkg::TICK_W-1:0]   remaining;
  logic                         running;
  logic                         last;

  modport source (output valid, kind, timer_id_res, remaining, running, last, input ready);
  modport sink   (input valid, kind, timer_id_res, remaining, running, last, output ready);
endinterface

// ===== src/delta_list_software_timer_queue_core.sv =====
`timescale 1ns / 1ps
// Delta-list software timer queue: list storage, sequencer and result register.
// Depends on dlq_pkg, dlq_in_if and dlq_out_if.
//
// Usage. Commands arrive as words on in_chan: a tick counts down the head of the
// list, a set (re)starts or stops one timer, a query reports how many ticks a
// timer has left, and a service fires expired timers. Results leave on out_chan,
// one word per fired timer, query or set, with last marking the final word of a
// command. A tick or service that fires nothing gives no word at all.
// cfg_we/cfg_wdata write the defer-firing bit; with it set, ticks only count down
// and expired timers wait for a service command.
//
// Timing. The block works on one command at a time and keeps in_chan.ready low from
// acceptance until the command is done; for a fire that is only after its word has
// been taken and the timer removed and, if periodic, put back. A query walks the
// list, a set searches, closes the gap, walks to the insertion point, opens a slot
// and sums the deltas, and each fired timer is removed and re-inserted. Each walk
// step reads one entry through the selected read port and writes at most one.
//
// Reset clears the list length, all reload values, the defer bit and the
// sequencer; list entries themselves are never read before they are written.
// When the receiver stalls, the result word is held in its register and the
// sequencer waits; nothing is lost or repeated.
module delta_list_software_timer_queue_core #(
  parameter int NUM_TIMERS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  dlq_in_if.sink     in_chan,
  dlq_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  // A position counter must also hold the list length itself, so it is one
  // value wider than an index.
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ACC_W  = dlq_pkg::TICK_W + CNT_W;
  localparam int SECOND = (NUM_TIMERS > 1) ? 1 : 0;
  localparam logic [CNT_W-1:0]           LEN_MAX  = CNT_W'(NUM_TIMERS);
  localparam logic [dlq_pkg::TICK_W-1:0] ID_LIMIT = dlq_pkg::TICK_W'(NUM_TIMERS);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_DISPATCH   = 10'b00_0000_0010,
    S_REM_SEARCH = 10'b00_0000_0100,
    S_REM_SHIFT  = 10'b00_0000_1000,
    S_AFTER_REM  = 10'b00_0001_0000,
    S_INS_WALK   = 10'b00_0010_0000,
    S_INS_SHIFT  = 10'b00_0100_0000,
    S_REPORT     = 10'b00_1000_0000,
    S_FIRE_CHECK = 10'b01_0000_0000,
    S_EMIT       = 10'b10_0000_0000
  } state_t;

  // The list is kept by position: entry p holds the slot id and its delta over
  // entry p-1. Reload values are kept per slot.
  logic [dlq_pkg::ID_W-1:0]   pos_slot_r  [NUM_TIMERS];
  logic [dlq_pkg::TICK_W-1:0] pos_delta_r [NUM_TIMERS];
  logic [dlq_pkg::TICK_W-1:0] reload_r    [NUM_TIMERS];

  state_t                     state_r, state_nxt;
  dlq_pkg::action_t           op_r, op_nxt;
  logic [dlq_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [dlq_pkg::TICK_W-1:0] start_r, start_nxt;
  logic [dlq_pkg::TICK_W-1:0] period_r, period_nxt;
  logic [CNT_W-1:0]           len_r, len_nxt;
  logic [CNT_W-1:0]           p_r, p_nxt;
  logic [CNT_W-1:0]           ins_pos_r, ins_pos_nxt;
  logic [dlq_pkg::TICK_W-1:0] rem_r, rem_nxt;
  logic [dlq_pkg::TICK_W-1:0] carry_r, carry_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [dlq_pkg::ID_W-1:0]   ins_id_r, ins_id_nxt;
  logic [dlq_pkg::ID_W-1:0]   fire_id_r, fire_id_nxt;
  logic                       defer_r;

  logic                       out_valid_r, out_valid_nxt;
  dlq_pkg::kind_t             out_kind_r, out_kind_nxt;
  logic [dlq_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic [dlq_pkg::TICK_W-1:0] out_remaining_r, out_remaining_nxt;
  logic                       out_running_r, out_running_nxt;
  logic                       out_last_r, out_last_nxt;

  // Single list read port and single write port.
  logic [CNT_W-1:0]           rd_sel;
  logic [IDX_W-1:0]           rd_idx;
  logic [dlq_pkg::ID_W-1:0]   rd_slot;
  logic [dlq_pkg::TICK_W-1:0] rd_delta;
  logic                       list_we;
  logic [CNT_W-1:0]           wr_sel;
  logic [dlq_pkg::ID_W-1:0]   wr_slot;
  logic [dlq_pkg::TICK_W-1:0] wr_delta;
  logic                       delta_only_we;
  logic                       reload_we;

  logic [IDX_W+1:0]           id_ext, fire_ext;
  logic [IDX_W-1:0]           id_idx, fire_idx;
  logic                       id_valid;
  logic [CNT_W-1:0]           p_inc, p_dec;
  logic [ACC_W-1:0]           sum;
  logic [dlq_pkg::TICK_W-1:0] head_delta;
  logic                       in_acc, out_acc;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = out_kind_r;
  assign out_chan.timer_id_res = out_id_r;
  assign out_chan.remaining    = out_remaining_r;
  assign out_chan.running      = out_running_r;
  assign out_chan.last         = out_last_r;

  assign id_ext   = {{IDX_W{1'b0}}, id_r};
  assign id_idx   = id_ext[IDX_W-1:0];
  assign fire_ext = {{IDX_W{1'b0}}, fire_id_r};
  assign fire_idx = fire_ext[IDX_W-1:0];
  assign id_valid = ({{(dlq_pkg::TICK_W - dlq_pkg::ID_W){1'b0}}, id_r} < ID_LIMIT);

  assign p_inc      = p_r + CNT_W'(1);
  assign p_dec      = p_r - CNT_W'(1);
  assign rd_idx     = rd_sel[IDX_W-1:0];
  assign rd_slot    = pos_slot_r[rd_idx];
  assign rd_delta   = pos_delta_r[rd_idx];
  assign head_delta = pos_delta_r[0];
  assign sum        = acc_r + ACC_W'(rd_delta);

  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    id_nxt            = id_r;
    start_nxt         = start_r;
    period_nxt        = period_r;
    len_nxt           = len_r;
    p_nxt             = p_r;
    ins_pos_nxt       = ins_pos_r;
    rem_nxt           = rem_r;
    carry_nxt         = carry_r;
    acc_nxt           = acc_r;
    ins_id_nxt        = ins_id_r;
    fire_id_nxt       = fire_id_r;
    out_valid_nxt     = out_valid_r;
    out_kind_nxt      = out_kind_r;
    out_id_nxt        = out_id_r;
    out_remaining_nxt = out_remaining_r;
    out_running_nxt   = out_running_r;
    out_last_nxt      = out_last_r;
    rd_sel            = p_r;
    list_we           = 1'b0;
    delta_only_we     = 1'b0;
    wr_sel            = p_r;
    wr_slot           = rd_slot;
    wr_delta          = rd_delta;
    reload_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = dlq_pkg::action_t'(in_chan.action);
          id_nxt     = in_chan.timer_id;
          start_nxt  = in_chan.start_value;
          period_nxt = in_chan.period;
          state_nxt  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        p_nxt   = '0;
        acc_nxt = '0;
        unique case (op_r)
          dlq_pkg::ACT_TICK: begin
            if (len_r == '0) begin
              state_nxt = S_IDLE;
            end else begin
              // Only the head counts down; an already expired head stays at zero.
              if (head_delta != '0) begin
                delta_only_we = 1'b1;
                wr_sel        = '0;
                wr_delta      = head_delta - dlq_pkg::TICK_W'(1);
              end
              state_nxt = defer_r ? S_IDLE : S_FIRE_CHECK;
            end
          end
          dlq_pkg::ACT_SET:     state_nxt = id_valid ? S_REM_SEARCH : S_REPORT;
          dlq_pkg::ACT_QUERY:   state_nxt = S_REPORT;
          dlq_pkg::ACT_SERVICE: state_nxt = S_FIRE_CHECK;
          default:              state_nxt = S_IDLE;
        endcase
      end

      S_REM_SEARCH: begin
        if (p_r == len_r) begin
          state_nxt = S_AFTER_REM;
        end else if (rd_slot == id_r) begin
          carry_nxt = rd_delta;
          state_nxt = S_REM_SHIFT;
        end else begin
          p_nxt = p_inc;
        end
      end

      // Close the gap: each later entry moves down one place, and the first of
      // them absorbs the delta of the removed entry.
      S_REM_SHIFT: begin
        rd_sel = p_inc;
        if (p_inc < len_r) begin
          list_we   = 1'b1;
          wr_sel    = p_r;
          wr_slot   = rd_slot;
          wr_delta  = rd_delta + carry_r;
          carry_nxt = '0;
          p_nxt     = p_inc;
        end else begin
          len_nxt   = len_r - CNT_W'(1);
          state_nxt = S_AFTER_REM;
        end
      end

      S_AFTER_REM: begin
        p_nxt   = '0;
        acc_nxt = '0;
        if (op_r == dlq_pkg::ACT_SET) begin
          // The reload value is kept even when the timer is being stopped.
          reload_we = 1'b1;
          if (start_r != '0) begin
            ins_id_nxt = id_r;
            rem_nxt    = start_r;
            state_nxt  = S_INS_WALK;
          end else begin
            state_nxt = S_REPORT;
          end
        end else if (reload_r[fire_idx] != '0) begin
          ins_id_nxt = fire_id_r;
          rem_nxt    = reload_r[fire_idx];
          state_nxt  = S_INS_WALK;
        end else begin
          state_nxt = S_FIRE_CHECK;
        end
      end

      // Walk past every entry that expires no later than the new one, so ties
      // land behind equal entries.
      S_INS_WALK: begin
        if (len_r == LEN_MAX) begin
          state_nxt = (op_r == dlq_pkg::ACT_SET) ? S_REPORT : S_FIRE_CHECK;
        end else if ((p_r < len_r) && (rd_delta <= rem_r)) begin
          rem_nxt = rem_r - rd_delta;
          p_nxt   = p_inc;
        end else begin
          if (p_r < len_r) begin
            delta_only_we = 1'b1;
            wr_sel        = p_r;
            wr_delta      = rd_delta - rem_r;
          end
          ins_pos_nxt = p_r;
          p_nxt       = len_r;
          state_nxt   = S_INS_SHIFT;
        end
      end

      // Open a slot from the tail down, then drop the new entry in.
      S_INS_SHIFT: begin
        rd_sel = p_dec;
        wr_sel = p_r;
        if (p_r > ins_pos_r) begin
          list_we  = 1'b1;
          wr_slot  = rd_slot;
          wr_delta = rd_delta;
          p_nxt    = p_dec;
        end else begin
          list_we   = 1'b1;
          wr_slot   = ins_id_r;
          wr_delta  = rem_r;
          len_nxt   = len_r + CNT_W'(1);
          p_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = (op_r == dlq_pkg::ACT_SET) ? S_REPORT : S_FIRE_CHECK;
        end
      end

      // Sum the deltas up to and including the addressed slot.
      S_REPORT: begin
        out_kind_nxt = (op_r == dlq_pkg::ACT_SET) ? dlq_pkg::K_SET_ACK : dlq_pkg::K_QUERY;
        out_id_nxt   = id_r;
        out_last_nxt = 1'b1;
        if (!id_valid || (p_r == len_r)) begin
          out_remaining_nxt = '0;
          out_running_nxt   = 1'b0;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_EMIT;
        end else if (rd_slot == id_r) begin
          out_remaining_nxt = (sum[ACC_W-1:dlq_pkg::TICK_W] != '0) ? '1
                              : sum[dlq_pkg::TICK_W-1:0];
          out_running_nxt   = 1'b1;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_EMIT;
        end else begin
          acc_nxt = sum;
          p_nxt   = p_inc;
        end
      end

      // A re-inserted periodic timer is always in the future, so another fire
      // follows exactly when the second entry is also expired.
      S_FIRE_CHECK: begin
        if ((len_r != '0) && (head_delta == '0)) begin
          fire_id_nxt       = pos_slot_r[0];
          out_kind_nxt      = dlq_pkg::K_FIRED;
          out_id_nxt        = pos_slot_r[0];
          out_remaining_nxt = '0;
          out_running_nxt   = 1'b0;
          out_last_nxt      = !((len_r >= CNT_W'(2)) && (pos_delta_r[SECOND] == '0));
          out_valid_nxt     = 1'b1;
          state_nxt         = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_EMIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_kind_r == dlq_pkg::K_FIRED) begin
            p_nxt     = '0;
            carry_nxt = '0;
            state_nxt = S_REM_SHIFT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      defer_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        defer_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r            <= op_nxt;
    id_r            <= id_nxt;
    start_r         <= start_nxt;
    period_r        <= period_nxt;
    p_r             <= p_nxt;
    ins_pos_r       <= ins_pos_nxt;
    rem_r           <= rem_nxt;
    carry_r         <= carry_nxt;
    acc_r           <= acc_nxt;
    ins_id_r        <= ins_id_nxt;
    fire_id_r       <= fire_id_nxt;
    out_kind_r      <= out_kind_nxt;
    out_id_r        <= out_id_nxt;
    out_remaining_r <= out_remaining_nxt;
    out_running_r   <= out_running_nxt;
    out_last_r      <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      pos_slot_r[wr_sel[IDX_W-1:0]]  <= wr_slot;
      pos_delta_r[wr_sel[IDX_W-1:0]] <= wr_delta;
    end else if (delta_only_we) begin
      pos_delta_r[wr_sel[IDX_W-1:0]] <= wr_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        reload_r[i] <= '0;
      end
    end else if (reload_we) begin
      reload_r[id_idx] <= period_r;
    end
  end

  // The list never holds more entries than there are timers.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("list length exceeds timer count");

  // The list grows or shrinks by at most one entry per cycle.
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((len_r == $past(len_r)) ||
                      (len_r == $past(len_r) + CNT_W'(1)) ||
                      (len_r == $past(len_r) - CNT_W'(1))))
    else $error("list length jumped");

  // The command port closes after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("command port stayed open after acceptance");

  // A query reply or set acknowledge ends its command.
  a_reply_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && (out_kind_r != dlq_pkg::K_FIRED)) |=> (state_r == S_IDLE))
    else $error("sequencer kept working after a final reply");

  // A result word is only presented while the sequencer waits for it.
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT))
    else $error("result valid outside the emit state");

endmodule

// ===== tb/sv/delta_list_software_timer_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for delta_list_software_timer_queue_core: random and directed
// command words against an in-bench delta-list predictor. Depends on dlq_pkg,
// dlq_in_if, dlq_out_if and the core itself.
module delta_list_software_timer_queue_core_tb;

  localparam int NUM_T       = 4;
  // The longest commands are a set and a service or tick that fires all four
  // timers. DRAIN_PAD gives a command that gives no word time to finish.
  localparam int DRAIN_PAD   = 100;
  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PCT    = 31;
  localparam int SHOW_MAX    = 10;

  // One command word as it goes into the block.
  typedef struct packed {
    dlq_pkg::action_t action;
    logic [1:0]       timer_id;
    logic [31:0]      start_value;
    logic [31:0]      period;
  } cmd_word_t;

  // One result word as the block should produce it.
  typedef struct packed {
    dlq_pkg::kind_t kind;
    logic [1:0]     timer_id;
    logic [31:0]    remaining;
    logic           running;
    logic           last;
  } timer_event_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dlq_in_if  in_chan ();
  dlq_out_if out_chan ();

  delta_list_software_timer_queue_core #(
    .NUM_TIMERS(NUM_T)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the delta list. list_order holds slot ids
  // from head to tail, slot_delta the ticks each listed slot lies beyond its
  // predecessor, slot_reload the period of each slot.
  // ---------------------------------------------------------------------------
  logic [1:0]  list_order  [NUM_T];
  logic [31:0] slot_delta  [NUM_T];
  logic [31:0] slot_reload [NUM_T];
  int          listed_count;
  logic        defer_model;

  timer_event_t timer_events_q[$];   // result words still owed by the block
  timer_event_t step_words[$];       // scratch list built while predicting one command
  cmd_word_t    pending_cmds[$];     // command words not yet driven

  cmd_word_t cur_cmd;
  int        words_queued;
  int        words_taken;
  int        mismatches;
  int        fires_seen;
  int        queries_seen;
  int        acks_seen;
  int        cycle_count;
  logic      calm;                   // when high neither side inserts idle cycles

  // Position of a slot in the list, or -1 when the timer is stopped.
  function automatic int list_pos(logic [1:0] id);
    for (int p = 0; p < listed_count; p++)
      if (list_order[p] == id)
        return p;
    return -1;
  endfunction

  // Take a slot out of the list. Its delta moves onto the successor so that
  // every later timer keeps its absolute expiry time.
  function automatic void unlink_timer(logic [1:0] id);
    int pos;
    pos = list_pos(id);
    if (pos < 0)
      return;
    if (pos + 1 < listed_count)
      slot_delta[list_order[pos + 1]] += slot_delta[id];
    for (int p = pos; p + 1 < listed_count; p++)
      list_order[p] = list_order[p + 1];
    listed_count--;
  endfunction

  // Walk the list while the entries expire no later than the new one, so a tie
  // goes behind the existing entries, then split the delta of the successor.
  function automatic void link_timer(logic [1:0] id, logic [31:0] value);
    logic [31:0] rest;
    int          pos;
    rest = value;
    pos  = 0;
    if (listed_count >= NUM_T)
      return;
    while (pos < listed_count && slot_delta[list_order[pos]] <= rest) begin
      rest -= slot_delta[list_order[pos]];
      pos++;
    end
    if (pos < listed_count)
      slot_delta[list_order[pos]] -= rest;
    for (int k = listed_count; k > pos; k--)
      list_order[k] = list_order[k - 1];
    list_order[pos] = id;
    slot_delta[id]  = rest;
    listed_count++;
  endfunction

  // Ticks left for a slot: the sum of the deltas up to and including it,
  // taken wide and clipped at 32 bits.
  function automatic logic [32:0] ticks_left(logic [1:0] id);
    logic [63:0] acc;
    acc = '0;
    if (list_pos(id) < 0)
      return '0;
    for (int p = 0; p < listed_count; p++) begin
      acc += slot_delta[list_order[p]];
      if (list_order[p] == id)
        break;
    end
    return {(acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0], 1'b1};
  endfunction

  function automatic void add_word(dlq_pkg::kind_t k, logic [1:0] id, logic [32:0] left);
    timer_event_t w;
    w.kind      = k;
    w.timer_id  = id;
    w.remaining = left[32:1];
    w.running   = left[0];
    w.last      = 1'b0;
    step_words.push_back(w);
  endfunction

  // Fire every expired head in turn. A periodic timer goes back in with its
  // reload value, which lies strictly in the future.
  function automatic void fire_due();
    logic [1:0] id;
    while (listed_count > 0 && slot_delta[list_order[0]] == 0 && step_words.size() < 16) begin
      id = list_order[0];
      add_word(dlq_pkg::K_FIRED, id, '0);
      unlink_timer(id);
      if (slot_reload[id] != 0)
        link_timer(id, slot_reload[id]);
    end
  endfunction

  // Apply one accepted command word and queue the result words it owes.
  function automatic void timer_list_step(cmd_word_t cmd);
    step_words.delete();
    case (cmd.action)
      dlq_pkg::ACT_TICK: begin
        if (listed_count > 0) begin
          if (slot_delta[list_order[0]] != 0)
            slot_delta[list_order[0]]--;
          if (!defer_model)
            fire_due();
        end
      end
      dlq_pkg::ACT_SET: begin
        unlink_timer(cmd.timer_id);
        slot_reload[cmd.timer_id] = cmd.period;
        if (cmd.start_value != 0)
          link_timer(cmd.timer_id, cmd.start_value);
        add_word(dlq_pkg::K_SET_ACK, cmd.timer_id, ticks_left(cmd.timer_id));
      end
      dlq_pkg::ACT_QUERY: add_word(dlq_pkg::K_QUERY, cmd.timer_id, ticks_left(cmd.timer_id));
      default:            fire_due();
    endcase
    if (step_words.size() > 0)
      step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i])
      timer_events_q.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock. Every block input gets a known value before the first edge.
  // ---------------------------------------------------------------------------
  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.action       = dlq_pkg::ACT_TICK;
    in_chan.timer_id     = '0;
    in_chan.start_value  = '0;
    in_chan.period       = '0;
    out_chan.ready       = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver. A word counts as taken at the edge where valid and ready are both
  // high; the predictor runs on it right there. A new word is presented only
  // once the current one has gone, and valid is written at most once per edge.
  // The defer bit of the predictor follows the register write at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      listed_count  = 0;
      defer_model   = 1'b0;
      words_taken   = 0;
      for (int i = 0; i < NUM_T; i++) begin
        slot_reload[i] = '0;
        slot_delta[i]  = '0;
        list_order[i]  = '0;
      end
    end else begin
      if (cfg_we)
        defer_model = cfg_wdata;
      if (in_chan.valid && in_chan.ready) begin
        timer_list_step(cur_cmd);
        words_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_cmd = pending_cmds.pop_front();
          in_chan.valid       <= 1'b1;
          in_chan.action      <= cur_cmd.action;
          in_chan.timer_id    <= cur_cmd.timer_id;
          in_chan.start_value <= cur_cmd.start_value;
          in_chan.period      <= cur_cmd.period;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each word taken on the result side is held against the oldest
  // expected word, field by field. A word with nothing owed is a failure too.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    timer_event_t want;
    timer_event_t got;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got.kind      = dlq_pkg::kind_t'(out_chan.kind);
        got.timer_id  = out_chan.timer_id_res;
        got.remaining = out_chan.remaining;
        got.running   = out_chan.running;
        got.last      = out_chan.last;
        case (got.kind)
          dlq_pkg::K_FIRED: fires_seen++;
          dlq_pkg::K_QUERY: queries_seen++;
          default:          acks_seen++;
        endcase
        if (timer_events_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("[%0t] unexpected word: kind %0d id %0d rem %0d run %0d last %0d",
                     $realtime, got.kind, got.timer_id, got.remaining, got.running, got.last);
        end else begin
          want = timer_events_q.pop_front();
          if (got.kind !== want.kind || got.timer_id !== want.timer_id ||
              got.remaining !== want.remaining || got.running !== want.running ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= SHOW_MAX) begin
              $display("[%0t] mismatch: expected kind %0d id %0d rem %0d run %0d last %0d",
                       $realtime, want.kind, want.timer_id, want.remaining, want.running,
                       want.last);
              $display("    got kind %0d id %0d rem %0d run %0d last %0d",
                       got.kind, got.timer_id, got.remaining, got.running, got.last);
            end
          end
        end
      end
      out_chan.ready <= calm || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               timer_events_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(dlq_pkg::action_t act, logic [1:0] id, logic [31:0] start_v,
                           logic [31:0] per);
    cmd_word_t c;
    c.action      = act;
    c.timer_id    = id;
    c.start_value = start_v;
    c.period      = per;
    pending_cmds.push_back(c);
    words_queued++;
  endtask

  // Hold off until every queued word is taken and every owed result has come,
  // then give a command that fires nothing time to finish inside the block.
  task automatic drain_block();
    while (words_taken != words_queued || timer_events_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_defer(logic value);
    drain_block();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Random commands shaped toward real use: ticks most often and mostly short timers so
  // that entries actually reach the head and fire, with stopped timers, long
  // and extreme values mixed in. Fields a command ignores still carry noise.
  task automatic queue_random(int count);
    int               pick;
    logic [31:0]      start_v;
    logic [31:0]      per;
    dlq_pkg::action_t act;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      act  = (pick < 40) ? dlq_pkg::ACT_TICK : (pick < 65) ? dlq_pkg::ACT_SET :
             (pick < 80) ? dlq_pkg::ACT_QUERY : dlq_pkg::ACT_SERVICE;
      start_v = $urandom;
      per     = $urandom;
      if (act == dlq_pkg::ACT_SET) begin
        pick = $urandom_range(99);
        if (pick < 60)
          start_v = $urandom_range(6, 1);
        else if (pick < 72)
          start_v = '0;
        else if (pick >= 86)
          start_v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1;
        pick = $urandom_range(99);
        if (pick < 45)
          per = '0;
        else if (pick < 85)
          per = $urandom_range(5, 1);
      end
      queue_cmd(act, 2'($urandom_range(3)), start_v, per);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    words_queued = 0;
    mismatches   = 0;
    fires_seen   = 0;
    queries_seen = 0;
    acks_seen    = 0;
    cycle_count  = 0;
    calm         = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Immediate firing. Tick and query on an empty list, a tie between two
    // timers due at the same time, the widest start and period, a stop that
    // still stores its period, and a service with nothing due.
    write_defer(1'b0);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(dlq_pkg::ACT_QUERY,   2'd2, '0, '0);
    queue_cmd(dlq_pkg::ACT_SET,     2'd0, 32'd3, 32'd0);
    queue_cmd(dlq_pkg::ACT_SET,     2'd1, 32'd3, 32'd2);
    queue_cmd(dlq_pkg::ACT_SET,     2'd2, 32'd1, 32'd0);
    queue_cmd(dlq_pkg::ACT_SET,     2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(dlq_pkg::ACT_QUERY,   2'd3, '0, '0);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd3, '0, '0);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd1, '0, '0);
    queue_cmd(dlq_pkg::ACT_QUERY,   2'd1, '0, '0);
    queue_cmd(dlq_pkg::ACT_SET,     2'd3, 32'd0, 32'd5);
    queue_cmd(dlq_pkg::ACT_QUERY,   2'd3, '0, '0);
    queue_cmd(dlq_pkg::ACT_SERVICE, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(dlq_pkg::ACT_SET,     2'd0, 32'd2, 32'd0);

    // Deferred firing. Timers expire on ticks but wait; a further tick finds
    // the head already at zero; service then fires them in list order.
    write_defer(1'b1);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_QUERY,   2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_SERVICE, 2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_SERVICE, 2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_SET,     2'd2, 32'd1, 32'd1);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd0, '0, '0);

    // Clearing the defer bit leaves the due timer waiting; the next tick,
    // with the head already at zero, fires it.
    write_defer(1'b0);
    queue_cmd(dlq_pkg::ACT_TICK,    2'd0, '0, '0);
    queue_cmd(dlq_pkg::ACT_SET,     2'd1, 32'd0, 32'd0);

    // Random phases. The first runs with no idle cycles on either side; each
    // phase change drains the block completely before the register write.
    write_defer(1'b0);
    calm = 1'b1;
    queue_random(35);
    drain_block();
    calm = 1'b0;
    write_defer(1'b1);
    queue_random(35);
    write_defer(1'b0);
    queue_random(35);

    drain_block();
    $display("%0d command words taken; %0d fires, %0d query replies, %0d set acks checked",
             words_taken, fires_seen, queries_seen, acks_seen);
    $display("covered immediate and deferred firing, ties, periodic reloads and stops");
    if (mismatches == 0 && timer_events_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, timer_events_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/dlq_pkg.sv
src/dlq_in_if.sv
src/dlq_out_if.sv
src/delta_list_software_timer_queue_core.sv
tb/sv/delta_list_software_timer_queue_core_tb.sv
